FILE: hw/rtl/fsrc_pkg.sv
// Shared types and constants for the frame sequence replay check.
package fsrc_pkg;

  localparam int unsigned WordWidth     = 32;
  localparam int unsigned CfgIndexWidth = 3;

  typedef logic [WordWidth-1:0] word_t;

  // Forward jump allowed when the window register holds zero
  localparam word_t DefaultWindow = 32'd64;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_MISMATCH  = 3'd1,
    VERDICT_DUPLICATE = 3'd2,
    VERDICT_GAP       = 3'd3,
    VERDICT_WINDOW    = 3'd4
  } verdict_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_ENFORCE_SESSION      = 3'd0,
    CFG_REJECT_GAPS          = 3'd1,
    CFG_REJECT_BEYOND_WINDOW = 3'd2,
    CFG_MAX_JUMP             = 3'd3,
    CFG_BOUND_SESSION        = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic  enforce_session;
    logic  reject_gaps;
    logic  reject_beyond_window;
    word_t max_jump;
    word_t bound_session;
  } cfg_t;

  typedef struct packed {
    word_t highest;
    logic  started;
    word_t dup_count;
    word_t missed_total;
    word_t gap_rej_count;
    word_t win_rej_count;
    word_t mismatch_count;
  } track_state_t;

endpackage

FILE: hw/rtl/fsrc_frame_if.sv
// Frame channel: session id and sequence number with valid/ready.
interface fsrc_frame_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_session;
  logic [31:0] frame_sequence;

  modport source (output valid, output frame_session, output frame_sequence, input ready);
  modport sink (input valid, input frame_session, input frame_sequence, output ready);
endinterface

FILE: hw/rtl/fsrc_result_if.sv
// Result channel: verdict and tracking counters with valid/ready.
interface fsrc_result_if import fsrc_pkg::*; ();
  logic     valid;
  logic     ready;
  verdict_t verdict;
  word_t    highest_seen;
  logic     tracking_on;
  word_t    duplicate_count;
  word_t    missed_total;
  word_t    gap_reject_count;
  word_t    window_reject_count;
  word_t    mismatch_count;

  modport source (
    output valid, output verdict, output highest_seen, output tracking_on,
    output duplicate_count, output missed_total, output gap_reject_count,
    output window_reject_count, output mismatch_count, input ready
  );
  modport sink (
    input valid, input verdict, input highest_seen, input tracking_on,
    input duplicate_count, input missed_total, input gap_reject_count,
    input window_reject_count, input mismatch_count, output ready
  );
endinterface

FILE: hw/rtl/fsrc_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
interface fsrc_cfg_if import fsrc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  word_t                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/fsrc_cfg_regs.sv
// Configuration register file written through the cfg channel.
module fsrc_cfg_regs import fsrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fsrc_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_ENFORCE_SESSION:      regs.enforce_session      <= cfg.data[0];
        CFG_REJECT_GAPS:          regs.reject_gaps          <= cfg.data[0];
        CFG_REJECT_BEYOND_WINDOW: regs.reject_beyond_window <= cfg.data[0];
        CFG_MAX_JUMP:             regs.max_jump             <= cfg.data;
        CFG_BOUND_SESSION:        regs.bound_session        <= cfg.data;
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/fsrc_classify.sv
// Classification of one frame against the tracking state; gives the next state.
module fsrc_classify import fsrc_pkg::*; (
  input  cfg_t         cfg,
  input  track_state_t st,
  input  word_t        frame_session,
  input  word_t        frame_sequence,
  output verdict_t     verdict,
  output track_state_t st_next
);

  word_t win;
  word_t skipped;
  word_t win_limit;
  logic  mismatch;

  assign win       = (cfg.max_jump == '0) ? DefaultWindow : cfg.max_jump;
  assign skipped   = frame_sequence - st.highest - 32'd1;
  // wraps modulo 2^32 before the compare
  assign win_limit = st.highest + win;
  assign mismatch  = cfg.enforce_session && (cfg.bound_session != '0) &&
                     (frame_session != '0) && (frame_session != cfg.bound_session);

  always_comb begin
    st_next = st;
    verdict = VERDICT_OK;
    if (mismatch) begin
      st_next.mismatch_count = st.mismatch_count + 32'd1;
      verdict = VERDICT_MISMATCH;
    end else if (frame_sequence == '0) begin
      // unsequenced word: accept, leave state alone
    end else if (!st.started) begin
      st_next.highest = frame_sequence;
      st_next.started = 1'b1;
    end else if (frame_sequence <= st.highest) begin
      st_next.dup_count = st.dup_count + 32'd1;
      verdict = VERDICT_DUPLICATE;
    end else begin
      // skipped count is booked even when the word is then rejected
      if (skipped != '0) begin
        st_next.missed_total = st.missed_total + skipped;
      end
      if ((skipped != '0) && cfg.reject_gaps) begin
        st_next.gap_rej_count = st.gap_rej_count + 32'd1;
        verdict = VERDICT_GAP;
      end else if (cfg.reject_beyond_window && (frame_sequence > win_limit)) begin
        st_next.win_rej_count = st.win_rej_count + 32'd1;
        verdict = VERDICT_WINDOW;
      end else begin
        st_next.highest = frame_sequence;
      end
    end
  end

endmodule

FILE: hw/rtl/frame_sequence_replay_check_unit.sv
// Top level of the frame sequence replay check: input register, classifier, result register.
//
//   channel | role | payload                                   | handshake
//   --------+------+-------------------------------------------+-------------
//   frame   | sink | frame_session, frame_sequence             | valid/ready
//   result  | src  | verdict, highest_seen, tracking_on, counts| valid/ready
//   cfg     | sink | index, data                               | valid/ready
//
// One frame per cycle sustained while the result is taken; a frame's result is presented
// once it has passed the input register, which it lands in on the accepting edge, and
// then the state/result register, which loads when the result is free to advance.
// The tracking state itself is the result register, so the next frame is classified against
// the updated state. Reset clears the state, the counters, the valid flags and the cfg registers.
// A stalled result holds the pipe; the input register refills while it drains.
module frame_sequence_replay_check_unit import fsrc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  fsrc_frame_if.sink    frame,
  fsrc_result_if.source result,
  fsrc_cfg_if.sink      cfg
);

  cfg_t         cfg_regs;
  logic         s1_valid;
  word_t        s1_session;
  word_t        s1_sequence;
  logic         out_valid;
  verdict_t     out_verdict;
  track_state_t st;
  track_state_t st_next;
  verdict_t     verdict_next;
  logic         advance;

  fsrc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  fsrc_classify u_classify (
    .cfg            (cfg_regs),
    .st             (st),
    .frame_session  (s1_session),
    .frame_sequence (s1_sequence),
    .verdict        (verdict_next),
    .st_next        (st_next)
  );

  assign advance     = s1_valid && (!out_valid || result.ready);
  assign frame.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      s1_session  <= frame.frame_session;
      s1_sequence <= frame.frame_sequence;
    end
  end

  // advance state and result together
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= '0;
      out_valid   <= 1'b0;
      out_verdict <= VERDICT_OK;
    end else if (advance) begin
      st          <= st_next;
      out_valid   <= 1'b1;
      out_verdict <= verdict_next;
    end else if (result.ready) begin
      out_valid   <= 1'b0;
    end
  end

  assign result.valid               = out_valid;
  assign result.verdict             = out_verdict;
  assign result.highest_seen        = st.highest;
  assign result.tracking_on         = st.started;
  assign result.duplicate_count     = st.dup_count;
  assign result.missed_total        = st.missed_total;
  assign result.gap_reject_count    = st.gap_rej_count;
  assign result.window_reject_count = st.win_rej_count;
  assign result.mismatch_count      = st.mismatch_count;

endmodule

FILE: hw/rtl/fsrc_checker.sv
// Port-level checks on the replay check unit, bound to the top level.
module fsrc_checker import fsrc_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     result_valid,
  input logic     result_ready,
  input verdict_t verdict,
  input word_t    highest_seen,
  input logic     tracking_on,
  input word_t    mismatch_count
);

  logic  last_tracking;
  word_t last_highest;
  word_t last_mismatch;
  logic  result_fire;

  assign result_fire = result_valid && result_ready;

  // remember what the last delivered word showed
  always_ff @(posedge clk) begin
    if (rst) begin
      last_tracking <= 1'b0;
      last_highest  <= '0;
      last_mismatch <= '0;
    end else if (result_fire) begin
      last_tracking <= tracking_on;
      last_highest  <= highest_seen;
      last_mismatch <= mismatch_count;
    end
  end

  a_reset_clears_valid: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid &&
      $stable({verdict, highest_seen, tracking_on, mismatch_count}))
    else $error("stalled result changed");

  a_tracking_sticky: assert property (@(posedge clk) disable iff (rst)
    result_fire && last_tracking |-> tracking_on)
    else $error("tracking dropped");

  a_mismatch_counts: assert property (@(posedge clk) disable iff (rst)
    result_fire && (verdict == VERDICT_MISMATCH) |->
      (mismatch_count == last_mismatch + 32'd1) && (highest_seen == last_highest))
    else $error("mismatch count or highest wrong");

  a_duplicate_keeps_highest: assert property (@(posedge clk) disable iff (rst)
    result_fire && (verdict == VERDICT_DUPLICATE) |->
      (highest_seen == last_highest) && (mismatch_count == last_mismatch))
    else $error("duplicate moved state");

endmodule

bind frame_sequence_replay_check_unit fsrc_checker u_fsrc_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .verdict        (result.verdict),
  .highest_seen   (result.highest_seen),
  .tracking_on    (result.tracking_on),
  .mismatch_count (result.mismatch_count)
);
